>>> rtl/core/kttc_pkg.sv
`default_nettype none

package kttc_pkg;

  localparam int unsigned SLOTS            = 16;
  localparam int unsigned SLOT_W           = $clog2(SLOTS);
  localparam int unsigned TICKS_PER_SECOND = 100;
  localparam int unsigned PHASE_W          = 10;
  localparam int unsigned CMD_W            = 2;
  localparam int unsigned HANDLE_W         = 5;
  localparam int unsigned KIND_W           = 3;
  localparam int unsigned TIME_W           = 32;

  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_START  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CANCEL = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd3;

  localparam logic [KIND_W-1:0] KIND_STARTED    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FULL       = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CANCELLED  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_UPDATED    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_EXPIRED    = 3'd4;
  localparam logic [KIND_W-1:0] KIND_TICK_DONE  = 3'd5;
  localparam logic [KIND_W-1:0] KIND_BAD_HANDLE = 3'd6;

  // per-slot control from the command decoder
  typedef struct packed {
    logic set;
    logic clr;
    logic wr;
  } cell_ctl_t;

endpackage

`default_nettype wire

>>> rtl/core/kttc_cell.sv
`default_nettype none

module kttc_cell (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          adv_i,
  input  wire  kttc_pkg::cell_ctl_t    ctl_i,
  input  wire  [kttc_pkg::TIME_W-1:0]  wdata_i,
  input  wire  [kttc_pkg::TIME_W-1:0]  now_i,
  input  wire                          tok_i,
  output logic                         tok_o,
  output logic                         active_o,
  output logic                         hit_o
);
  import kttc_pkg::*;

  logic              tok_q;
  logic              active_q, active_d;
  logic [TIME_W-1:0] exp_q;
  logic [TIME_W-1:0] diff;
  logic              expired;

  assign diff    = exp_q - now_i;
  assign expired = (diff == '0) || diff[TIME_W-1];
  assign hit_o   = tok_q & active_q & expired;

  always_comb begin
    active_d = active_q;
    priority if (ctl_i.set) begin
      active_d = 1'b1;
    end else if (ctl_i.clr) begin
      active_d = 1'b0;
    end else if (hit_o && adv_i) begin
      active_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q    <= 1'b0;
      active_q <= 1'b0;
    end else begin
      if (adv_i) begin
        tok_q <= tok_i;
      end
      active_q <= active_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr) begin
      exp_q <= wdata_i;
    end
  end

  assign tok_o    = tok_q;
  assign active_o = active_q;

endmodule

`default_nettype wire

>>> rtl/core/kernel_timer_table_core.sv
`default_nettype none

// One-shot timer table: 16 slots in a chain of cells, each holding its active bit and
// 32-bit expiry. Start, cancel and update each return one word. A tick sends a scan
// token down the chain, one slot per cycle while the output does not stall, emitting
// an expired word for each due slot in slot order and then a tick-done word. A tick
// keeps the block busy from its accept through the token's pass along the chain to the
// summary; the chain length sets how long, and an output stall holds the scan.
// No new word is taken until the scan's summary is out.

module kernel_timer_table_core (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            in_valid_i,
  output logic                           in_ready_o,
  input  wire  [kttc_pkg::CMD_W-1:0]     command_i,
  input  wire  [kttc_pkg::HANDLE_W-1:0]  handle_i,
  input  wire  [kttc_pkg::TIME_W-1:0]    delay_i,
  output logic                           out_valid_o,
  input  wire                            out_ready_i,
  output logic [kttc_pkg::KIND_W-1:0]    kind_o,
  output logic [kttc_pkg::HANDLE_W-1:0]  handle_res_o,
  output logic [kttc_pkg::TIME_W-1:0]    ticks_o,
  output logic [kttc_pkg::TIME_W-1:0]    seconds_o,
  output logic                           last_o
);
  import kttc_pkg::*;

  logic                busy_q, busy_d;
  logic                tail_q;
  logic [TIME_W-1:0]   tick_q, tick_d;
  logic [TIME_W-1:0]   sec_q, sec_d;
  logic [PHASE_W-1:0]  phase_q, phase_d, phase_inc;

  logic                out_valid_q, out_valid_d;
  logic [KIND_W-1:0]   kind_q, kind_d;
  logic [HANDLE_W-1:0] hres_q, hres_d;
  logic [TIME_W-1:0]   ticks_q, ticks_d;
  logic [TIME_W-1:0]   secs_q, secs_d;
  logic                last_q, last_d;

  logic                adv;
  logic                acc;
  logic                tick_acc;
  logic [SLOTS:0]      tok;
  logic [SLOTS-1:0]    active;
  logic [SLOTS-1:0]    hit;
  cell_ctl_t           ctl [SLOTS];
  logic [TIME_W-1:0]   wdata;

  logic                full;
  logic [SLOT_W-1:0]   free_idx;
  logic                hnd_ok;
  logic [SLOT_W-1:0]   hnd_idx;
  logic [HANDLE_W-1:0] hit_hnd;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = !busy_q && adv;
  assign acc        = in_valid_i && in_ready_o;
  assign tick_acc   = acc && (command_i == CMD_TICK);
  assign tok[0]     = tick_acc;
  assign wdata      = tick_q + delay_i;

  assign full     = &active;
  assign hnd_ok   = (handle_i != '0) && (handle_i <= HANDLE_W'(SLOTS));
  assign hnd_idx  = SLOT_W'(handle_i - HANDLE_W'(1));

  always_comb begin
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!active[i]) begin
        free_idx = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    hit_hnd = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (hit[i]) begin
        hit_hnd = hit_hnd | HANDLE_W'(i + 1);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      ctl[i].set = acc && (command_i == CMD_START) && !full && (free_idx == SLOT_W'(i));
      ctl[i].clr = acc && (command_i == CMD_CANCEL) && hnd_ok && (hnd_idx == SLOT_W'(i));
      ctl[i].wr  = ctl[i].set ||
                   (acc && (command_i == CMD_UPDATE) && hnd_ok && (hnd_idx == SLOT_W'(i)));
    end
  end

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    kttc_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .adv_i    (adv),
      .ctl_i    (ctl[g]),
      .wdata_i  (wdata),
      .now_i    (tick_q),
      .tok_i    (tok[g]),
      .tok_o    (tok[g+1]),
      .active_o (active[g]),
      .hit_o    (hit[g])
    );
  end

  assign phase_inc = phase_q + PHASE_W'(1);

  always_comb begin
    tick_d  = tick_q;
    sec_d   = sec_q;
    phase_d = phase_q;
    if (tick_acc) begin
      tick_d = tick_q + TIME_W'(1);
      if (phase_inc >= PHASE_W'(TICKS_PER_SECOND)) begin
        phase_d = '0;
        sec_d   = sec_q + TIME_W'(1);
      end else begin
        phase_d = phase_inc;
      end
    end
  end

  always_comb begin
    busy_d      = busy_q;
    out_valid_d = out_valid_q;
    kind_d      = kind_q;
    hres_d      = hres_q;
    ticks_d     = ticks_q;
    secs_d      = secs_q;
    last_d      = last_q;
    if (adv) begin
      out_valid_d = 1'b0;
      ticks_d     = tick_d;
      secs_d      = sec_d;
      hres_d      = '0;
      last_d      = 1'b1;
      if (busy_q) begin
        if (tail_q) begin
          out_valid_d = 1'b1;
          kind_d      = KIND_TICK_DONE;
          busy_d      = 1'b0;
        end else if (|hit) begin
          out_valid_d = 1'b1;
          kind_d      = KIND_EXPIRED;
          hres_d      = hit_hnd;
          last_d      = 1'b0;
        end
      end else if (acc) begin
        unique case (command_i)
          CMD_TICK: begin
            busy_d = 1'b1;
          end
          CMD_START: begin
            out_valid_d = 1'b1;
            if (full) begin
              kind_d = KIND_FULL;
            end else begin
              kind_d = KIND_STARTED;
              hres_d = HANDLE_W'(free_idx) + HANDLE_W'(1);
            end
          end
          CMD_CANCEL: begin
            out_valid_d = 1'b1;
            kind_d      = hnd_ok ? KIND_CANCELLED : KIND_BAD_HANDLE;
          end
          default: begin
            out_valid_d = 1'b1;
            kind_d      = hnd_ok ? KIND_UPDATED : KIND_BAD_HANDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      tail_q      <= 1'b0;
      tick_q      <= '0;
      sec_q       <= '0;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      if (adv) begin
        tail_q <= tok[SLOTS];
      end
      tick_q      <= tick_d;
      sec_q       <= sec_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    hres_q  <= hres_d;
    ticks_q <= ticks_d;
    secs_q  <= secs_d;
    last_q  <= last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = kind_q;
  assign handle_res_o = hres_q;
  assign ticks_o      = ticks_q;
  assign seconds_o    = secs_q;
  assign last_o       = last_q;

endmodule

`default_nettype wire

>>> dv/tb_kernel_timer_table_core.sv
`default_nettype none

module tb_kernel_timer_table_core;
  import kttc_pkg::*;

  localparam int unsigned CLK_HALF       = 10;
  localparam int unsigned RST_CYCLES     = 9;
  localparam int unsigned RX_HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES   = 40;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam int unsigned RANDOM_WORDS   = 360;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [HANDLE_W-1:0] handle;
    logic [TIME_W-1:0]   ticks;
    logic [TIME_W-1:0]   seconds;
    logic                last;
  } timer_word_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic [CMD_W-1:0]    command_i   = CMD_TICK;
  logic [HANDLE_W-1:0] handle_i    = '0;
  logic [TIME_W-1:0]   delay_i     = '0;
  logic                out_ready_i = 1'b0;
  logic                in_ready_o;
  logic                out_valid_o;
  logic [KIND_W-1:0]   kind_o;
  logic [HANDLE_W-1:0] handle_res_o;
  logic [TIME_W-1:0]   ticks_o;
  logic [TIME_W-1:0]   seconds_o;
  logic                last_o;

  kernel_timer_table_core u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .handle_i     (handle_i),
    .delay_i      (delay_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .handle_res_o (handle_res_o),
    .ticks_o      (ticks_o),
    .seconds_o    (seconds_o),
    .last_o       (last_o)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // timer table mirror
  logic               slot_armed [SLOTS] = '{default: 1'b0};
  logic [TIME_W-1:0]  slot_due   [SLOTS] = '{default: '0};
  logic [TIME_W-1:0]  tick_now  = '0;
  logic [TIME_W-1:0]  sec_now   = '0;
  logic [PHASE_W-1:0] sec_phase = '0;
  timer_word_t        due_words [$];

  int unsigned fail_count = 0;
  int unsigned burst_left = 0;
  int unsigned hold_req   = 0;

  function automatic timer_word_t timer_word(input logic [KIND_W-1:0] kind,
                                             input logic [HANDLE_W-1:0] hnd,
                                             input logic last);
    timer_word_t w;
    w.kind    = kind;
    w.handle  = hnd;
    w.ticks   = tick_now;
    w.seconds = sec_now;
    w.last    = last;
    return w;
  endfunction

  function automatic void timer_table_apply(input logic [CMD_W-1:0] cmd,
                                            input logic [HANDLE_W-1:0] hnd,
                                            input logic [TIME_W-1:0] dly);
    int slot;
    logic [TIME_W-1:0] diff;
    slot = 0;
    case (cmd)
      CMD_TICK: begin
        tick_now  = tick_now + 1'b1;
        sec_phase = sec_phase + 1'b1;
        if (sec_phase >= TICKS_PER_SECOND) begin
          sec_phase = '0;
          sec_now   = sec_now + 1'b1;
        end
        for (slot = 0; slot < SLOTS; slot++) begin
          if (slot_armed[slot]) begin
            diff = slot_due[slot] - tick_now;
            if (diff == '0 || diff[TIME_W-1]) begin
              slot_armed[slot] = 1'b0;
              due_words.push_back(timer_word(KIND_EXPIRED, HANDLE_W'(slot + 1), 1'b0));
            end
          end
        end
        due_words.push_back(timer_word(KIND_TICK_DONE, '0, 1'b1));
      end
      CMD_START: begin
        while (slot < SLOTS && slot_armed[slot]) slot++;
        if (slot >= SLOTS) begin
          due_words.push_back(timer_word(KIND_FULL, '0, 1'b1));
        end else begin
          slot_armed[slot] = 1'b1;
          slot_due[slot]   = tick_now + dly;
          due_words.push_back(timer_word(KIND_STARTED, HANDLE_W'(slot + 1), 1'b1));
        end
      end
      default: begin
        if (hnd < 1 || hnd > SLOTS) begin
          due_words.push_back(timer_word(KIND_BAD_HANDLE, '0, 1'b1));
        end else if (cmd == CMD_CANCEL) begin
          slot_armed[hnd - 1] = 1'b0;
          due_words.push_back(timer_word(KIND_CANCELLED, '0, 1'b1));
        end else begin
          slot_due[hnd - 1] = tick_now + dly;
          due_words.push_back(timer_word(KIND_UPDATED, '0, 1'b1));
        end
      end
    endcase
  endfunction

  // input words are mirrored before output words are checked at the same edge
  always @(posedge clk_i) begin : scoreboard
    timer_word_t got;
    timer_word_t want;
    if (rst_ni && in_valid_i && in_ready_o) begin
      timer_table_apply(command_i, handle_i, delay_i);
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{kind_o, handle_res_o, ticks_o, seconds_o, last_o};
      if (due_words.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
          $display("unexpected word: kind %0d handle %0d ticks %0d seconds %0d last %0d",
                   got.kind, got.handle, got.ticks, got.seconds, got.last);
        end
      end else begin
        want = due_words.pop_front();
        if (got.kind !== want.kind || got.handle !== want.handle ||
            got.ticks !== want.ticks || got.seconds !== want.seconds ||
            got.last !== want.last) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("mismatch: exp kind %0d handle %0d ticks %0d seconds %0d last %0d",
                     want.kind, want.handle, want.ticks, want.seconds, want.last);
            $display("          got kind %0d handle %0d ticks %0d seconds %0d last %0d",
                     got.kind, got.handle, got.ticks, got.seconds, got.last);
          end
        end
      end
    end
  end

  initial begin : receiver
    int unsigned hold_seen;
    int unsigned phase_left;
    int unsigned rx_mode;
    logic [7:0]  ready_mask;
    hold_seen  = 0;
    phase_left = 0;
    rx_mode    = 0;
    ready_mask = 8'hff;
    forever begin
      @(posedge clk_i);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        out_ready_i <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk_i);
      end else begin
        if (phase_left == 0) begin
          rx_mode    = $urandom_range(0, 2);
          ready_mask = 8'($urandom()) | 8'h01;
          phase_left = $urandom_range(16, 96);
        end
        phase_left--;
        case (rx_mode)
          0: out_ready_i <= 1'b1;
          1: begin
            out_ready_i <= ready_mask[0];
            ready_mask = {ready_mask[0], ready_mask[7:1]};
          end
          default: out_ready_i <= ($urandom_range(0, 2) != 0);
        endcase
      end
    end
  end

  task automatic issue_cmd(input logic [CMD_W-1:0] cmd, input logic [HANDLE_W-1:0] hnd,
                           input logic [TIME_W-1:0] dly);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    handle_i   <= hnd;
    delay_i    <= dly;
    do @(posedge clk_i); while (!in_ready_o);
    burst_left--;
  endtask

  // mostly short delays so slots expire within the run; some near the sign boundary
  function automatic logic [TIME_W-1:0] pick_delay();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 13) return $urandom_range(0, 48);
    if (r < 16) return $urandom();
    if (r < 18) return 32'h7fff_fff0 + $urandom_range(0, 32);
    return 32'hffff_ffe0 + $urandom_range(0, 31);
  endfunction

  task automatic test_directed();
    issue_cmd(CMD_TICK, 5'd31, 32'hffff_ffff);
    issue_cmd(CMD_START, 5'd0, 32'd0);
    issue_cmd(CMD_START, 5'd31, 32'd1);
    issue_cmd(CMD_START, 5'd16, 32'hffff_ffff);  // due on the next tick
    issue_cmd(CMD_START, 5'd1, 32'h8000_0000);
    issue_cmd(CMD_START, 5'd0, 32'h7fff_ffff);
    repeat (SLOTS - 5) issue_cmd(CMD_START, 5'($urandom_range(0, 31)), $urandom_range(2, 40));
    issue_cmd(CMD_START, 5'd0, 32'd3);           // table full
    issue_cmd(CMD_CANCEL, 5'd0, '0);
    issue_cmd(CMD_UPDATE, 5'd17, 32'hffff_ffff);
    issue_cmd(CMD_CANCEL, 5'd31, '0);
    issue_cmd(CMD_CANCEL, 5'd2, '0);
    issue_cmd(CMD_CANCEL, 5'd2, '0);             // already free
    issue_cmd(CMD_UPDATE, 5'd2, 32'd1);          // free slot: expiry only
    issue_cmd(CMD_UPDATE, 5'd16, 32'd0);
    issue_cmd(CMD_TICK, 5'd0, '0);
  endtask

  task automatic test_output_stall();
    hold_req++;
    repeat (30) begin
      if ($urandom_range(0, 1) != 0) issue_cmd(CMD_TICK, 5'($urandom_range(0, 31)), $urandom());
      else issue_cmd(CMD_START, 5'($urandom_range(0, 31)), pick_delay());
    end
  endtask

  task automatic test_random_traffic(input int unsigned count);
    int unsigned r;
    logic [CMD_W-1:0] cmd;
    logic [HANDLE_W-1:0] hnd;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 42) cmd = CMD_TICK;
      else if (r < 70) cmd = CMD_START;
      else if (r < 85) cmd = CMD_CANCEL;
      else cmd = CMD_UPDATE;
      if ($urandom_range(0, 5) == 0) hnd = 5'($urandom_range(0, 31));
      else hnd = 5'($urandom_range(1, SLOTS));
      issue_cmd(cmd, hnd, pick_delay());
    end
  endtask

  initial begin : stimulus
    repeat (RST_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_output_stall();
    test_random_traffic(RANDOM_WORDS);
    in_valid_i <= 1'b0;
    while (due_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_kernel_timer_table_core: clean");
    end else begin
      $display("tb_kernel_timer_table_core: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #(12_000_000);
    $display("tb_kernel_timer_table_core: errors");
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
rtl/core/kttc_pkg.sv
rtl/core/kttc_cell.sv
rtl/core/kernel_timer_table_core.sv
dv/tb_kernel_timer_table_core.sv
